/* hdl/rtps_pkg.sv */
// ----------------------------------------------------------------------------
// rtps_pkg
// Shared types and codes of the release-time priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rtps_pkg;
    localparam logic [15:0] START_RESET = 16'd2011;

    localparam logic [0:0] CFG_START_TIME = 1'b0;
    localparam logic [0:0] CFG_WATCHED    = 1'b1;

    localparam logic [1:0] ST_INSERT_OK = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_SERVED    = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RPUSH_RD,
        S_RPUSH_CMP,
        S_PPUSH_RD,
        S_PPUSH_CMP,
        S_MOVE_CHK,
        S_PPOP_LAST,
        S_PPOP_LASTW,
        S_PPOP_RD,
        S_PPOP_C1,
        S_PPOP_C2,
        S_PPOP_CMP,
        S_RPOP_TOP,
        S_RPOP_LAST,
        S_RPOP_LASTW,
        S_RPOP_RD,
        S_RPOP_C1,
        S_RPOP_C2,
        S_RPOP_CMP,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/release_time_priority_scheduler_top.sv */
// ----------------------------------------------------------------------------
// release_time_priority_scheduler_top
// Two heaps, each in a one-port synchronous memory: ready max-heap of priorities,
// pending heap of (release time, priority): earliest first, ties to higher priority.
// ----------------------------------------------------------------------------
// channel | direction | handshake      | payload
// in      | input     | valid / stall  | kind, release_time, priority_req
// out     | output    | valid / stall  | status, served_priority, served_time,
//         |           |                | is_watched
// cfg     | input     | cfg_we         | cfg_index, cfg_data
//
// One item at a time. An insert climbs its heap, comparing one parent per step. A
// tick first checks the pending head and, while it is due and the ready heap has
// room, pops it and pushes its priority into the ready heap; it then serves the
// ready top with a sift-down, or reports an empty tick, and advances the time.
// No clearing pass: counts reset to zero. A result waits in the output register;
// the input stays stalled until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module release_time_priority_scheduler_top
    import rtps_pkg::*;
#(
    parameter int CAPACITY = 1024
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] release_time,
    input  wire logic [31:0] priority_req,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      served_priority,
    output logic [15:0]      served_time,
    output logic             is_watched,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [31:0] rmem [CAPACITY];
    logic [47:0] pmem [CAPACITY];

    state_t state_reg, state_next;
    logic [CW-1:0] rcnt_reg, rcnt_next, pcnt_reg, pcnt_next;
    logic [15:0]   time_reg, time_next;
    logic [31:0]   watch_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [47:0]   val_reg, val_next;
    logic [47:0]   c1_reg, c1_next;
    logic [31:0]   top_reg, top_next;
    logic          out_valid_reg;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   spri_reg, spri_next;
    logic [15:0]   stime_reg, stime_next;
    logic          watched_reg, watched_next;
    logic          load_out;
    logic          kind_tick_reg;

    logic          r_we, p_we;
    logic [AW-1:0] r_addr, p_addr;
    logic [31:0]   r_wdata, r_rdata;
    logic [47:0]   p_wdata, p_rdata;

    logic [AW:0]   child1;
    logic [AW-1:0] parent;

    function automatic logic pend_before(input logic [47:0] a, input logic [47:0] b);
        if (a[47:32] != b[47:32])
            return a[47:32] < b[47:32];
        return a[31:0] > b[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (r_we)
            rmem[r_addr] <= r_wdata;
        r_rdata <= rmem[r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_addr] <= p_wdata;
        p_rdata <= pmem[p_addr];
    end

    assign child1   = {idx_reg, 1'b1};
    assign parent   = AW'((idx_reg - 1'b1) >> 1);
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign served_priority = spri_reg;
    assign served_time     = stime_reg;
    assign is_watched      = watched_reg;

    always_comb
    begin
        state_next   = state_reg;
        rcnt_next    = rcnt_reg;
        pcnt_next    = pcnt_reg;
        time_next    = time_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        c1_next      = c1_reg;
        top_next     = top_reg;
        status_next  = status_reg;
        spri_next    = spri_reg;
        stime_next   = stime_reg;
        watched_next = watched_reg;
        load_out     = 1'b0;
        r_we = 1'b0; r_addr = idx_reg; r_wdata = val_reg[31:0];
        p_we = 1'b0; p_addr = idx_reg; p_wdata = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    spri_next = '0; stime_next = '0; watched_next = 1'b0;
                    status_next = ST_INSERT_OK;
                    if (kind)
                    begin
                        stime_next = time_reg;
                        state_next = S_MOVE_CHK;
                    end
                    else if (release_time <= time_reg)
                    begin
                        if (rcnt_reg >= CAP_C)
                        begin
                            status_next = ST_DROPPED; state_next = S_OUT;
                        end
                        else
                        begin
                            val_next = {16'd0, priority_req};
                            idx_next = AW'(rcnt_reg);
                            rcnt_next = rcnt_reg + 1'b1;
                            state_next = S_RPUSH_RD;
                        end
                    end
                    else
                    begin
                        if (pcnt_reg >= CAP_C)
                        begin
                            status_next = ST_DROPPED; state_next = S_OUT;
                        end
                        else
                        begin
                            val_next = {release_time, priority_req};
                            idx_next = AW'(pcnt_reg);
                            pcnt_next = pcnt_reg + 1'b1;
                            state_next = S_PPUSH_RD;
                        end
                    end
                end
            end
            S_RPUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    r_we = 1'b1;
                    state_next = (kind_tick_reg) ? S_MOVE_CHK : S_OUT;
                end
                else
                begin
                    r_addr = parent;
                    state_next = S_RPUSH_CMP;
                end
            end
            S_RPUSH_CMP:
            begin
                if (r_rdata >= val_reg[31:0])
                begin
                    r_we = 1'b1;
                    state_next = (kind_tick_reg) ? S_MOVE_CHK : S_OUT;
                end
                else
                begin
                    r_we = 1'b1; r_wdata = r_rdata;
                    idx_next = parent;
                    state_next = S_RPUSH_RD;
                end
            end
            S_PPUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    p_we = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    p_addr = parent; state_next = S_PPUSH_CMP;
                end
            end
            S_PPUSH_CMP:
            begin
                if (!pend_before(val_reg, p_rdata))
                begin
                    p_we = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    p_we = 1'b1; p_wdata = p_rdata;
                    idx_next = parent; state_next = S_PPUSH_RD;
                end
            end
            S_MOVE_CHK:
            begin
                p_addr = '0;
                if (pcnt_reg != '0 && rcnt_reg < CAP_C)
                    state_next = S_PPOP_LAST;
                else
                    state_next = S_RPOP_TOP;
            end
            S_PPOP_LAST:
            begin
                if (p_rdata[47:32] <= time_reg)
                begin
                    top_next = p_rdata[31:0];
                    p_addr = AW'(pcnt_reg - 1'b1);
                    pcnt_next = pcnt_reg - 1'b1;
                    state_next = S_PPOP_LASTW;
                end
                else
                    state_next = S_RPOP_TOP;
            end
            S_PPOP_LASTW:
            begin
                val_next = p_rdata;
                idx_next = '0;
                state_next = S_PPOP_RD;
            end
            S_PPOP_RD:
            begin
                if (child1 >= (AW+1)'(pcnt_reg))
                begin
                    if (pcnt_reg != '0) p_we = 1'b1;
                    val_next = {16'd0, top_reg};
                    idx_next = AW'(rcnt_reg);
                    rcnt_next = rcnt_reg + 1'b1;
                    state_next = S_RPUSH_RD;
                end
                else
                begin
                    p_addr = AW'(child1); state_next = S_PPOP_C1;
                end
            end
            S_PPOP_C1:
            begin
                c1_next = p_rdata;
                p_addr = AW'(child1 + 1'b1);
                state_next = S_PPOP_C2;
            end
            S_PPOP_C2:
            begin
                if ((child1 + 1'b1) < (AW+1)'(pcnt_reg) && pend_before(p_rdata, c1_reg))
                begin
                    c1_next = p_rdata;
                    idx_next = AW'(child1 + 1'b1);
                end
                else
                    idx_next = AW'(child1);
                top_next = top_reg;
                state_next = S_PPOP_CMP;
                val_next = val_reg;
                // idx_next now addresses chosen child; keep old slot in val's write
                p_addr = idx_reg;
                if (!pend_before(((child1 + 1'b1) < (AW+1)'(pcnt_reg)
                        && pend_before(p_rdata, c1_reg)) ? p_rdata : c1_reg, val_reg))
                begin
                    p_we = 1'b1;
                    idx_next = idx_reg;
                    val_next = {16'd0, top_reg};
                    idx_next = AW'(rcnt_reg);
                    rcnt_next = rcnt_reg + 1'b1;
                    state_next = S_RPUSH_RD;
                end
                else
                begin
                    p_we = 1'b1;
                    p_wdata = ((child1 + 1'b1) < (AW+1)'(pcnt_reg)
                        && pend_before(p_rdata, c1_reg)) ? p_rdata : c1_reg;
                    state_next = S_PPOP_RD;
                end
            end
            S_PPOP_CMP:
            begin
                state_next = S_PPOP_RD;
            end
            S_RPOP_TOP:
            begin
                r_addr = '0;
                if (rcnt_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    time_next = time_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_RPOP_LAST;
            end
            S_RPOP_LAST:
            begin
                top_next = r_rdata;
                r_addr = AW'(rcnt_reg - 1'b1);
                rcnt_next = rcnt_reg - 1'b1;
                state_next = S_RPOP_LASTW;
            end
            S_RPOP_LASTW:
            begin
                val_next = {16'd0, r_rdata};
                idx_next = '0;
                state_next = S_RPOP_RD;
            end
            S_RPOP_RD:
            begin
                if (child1 >= (AW+1)'(rcnt_reg))
                begin
                    if (rcnt_reg != '0) r_we = 1'b1;
                    state_next = S_RPOP_CMP;
                end
                else
                begin
                    r_addr = AW'(child1); state_next = S_RPOP_C1;
                end
            end
            S_RPOP_C1:
            begin
                c1_next = {16'd0, r_rdata};
                r_addr = AW'(child1 + 1'b1);
                state_next = S_RPOP_C2;
            end
            S_RPOP_C2:
            begin
                if ((child1 + 1'b1) < (AW+1)'(rcnt_reg) && r_rdata > c1_reg[31:0])
                begin
                    c1_next = {16'd0, r_rdata};
                    idx_next = AW'(child1 + 1'b1);
                end
                else
                    idx_next = AW'(child1);
                if ((((child1 + 1'b1) < (AW+1)'(rcnt_reg) && r_rdata > c1_reg[31:0])
                        ? r_rdata : c1_reg[31:0]) <= val_reg[31:0])
                begin
                    r_we = 1'b1;
                    idx_next = idx_reg;
                    state_next = S_RPOP_CMP;
                end
                else
                begin
                    r_we = 1'b1;
                    r_wdata = ((child1 + 1'b1) < (AW+1)'(rcnt_reg)
                        && r_rdata > c1_reg[31:0]) ? r_rdata : c1_reg[31:0];
                    state_next = S_RPOP_RD;
                end
            end
            S_RPOP_CMP:
            begin
                status_next  = ST_SERVED;
                spri_next    = top_reg;
                watched_next = (top_reg == watch_reg);
                time_next    = time_reg + 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcnt_reg      <= '0;
            pcnt_reg      <= '0;
            time_reg      <= START_RESET;
            watch_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_tick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            pcnt_reg  <= pcnt_next;
            if (cfg_we && cfg_index == CFG_START_TIME)
                time_reg <= cfg_data[15:0];
            else
                time_reg <= time_next;
            if (cfg_we && cfg_index == CFG_WATCHED)
                watch_reg <= cfg_data;
            if (state_reg == S_IDLE && in_valid && !in_stall)
                kind_tick_reg <= kind;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        c1_reg      <= c1_next;
        top_reg     <= top_next;
        status_reg  <= status_next;
        spri_reg    <= spri_next;
        stime_reg   <= stime_next;
        watched_reg <= watched_next;
    end

    a_cnt_r: assert property (@(posedge clk) disable iff (!rst_n) rcnt_reg <= CAP_C)
        else $error("ready count over capacity");
    a_cnt_p: assert property (@(posedge clk) disable iff (!rst_n) pcnt_reg <= CAP_C)
        else $error("pending count over capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input open while busy");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("result lost");
endmodule
`default_nettype wire

/* sim/release_time_priority_scheduler_top_test.sv */
// ----------------------------------------------------------------------------
// release_time_priority_scheduler_top_test
// Self-checking bench: drives inserts and ticks with random gaps and stalls,
// predicts every result with its own two-heap scheduler and compares them.
// ----------------------------------------------------------------------------
`default_nettype none

class sched_scoreboard;
    localparam int CAP = 1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] prio;
        logic [15:0] stime;
        logic        watched;
    } sched_result_t;

    logic [15:0]   cur_time;
    logic [31:0]   watch_prio;
    logic [31:0]   ready_q[$];
    logic [47:0]   pend_q[$];
    sched_result_t expected_q[$];
    int            errors;

    function new();
        cur_time = rtps_pkg::START_RESET;
        watch_prio = '0;
        errors = 0;
    endfunction

    function void set_start(logic [15:0] t);
        cur_time = t;
    endfunction

    function void set_watch(logic [31:0] p);
        watch_prio = p;
    endfunction

    function void ready_push(logic [31:0] v);
        int i;
        int p;
        i = ready_q.size();
        ready_q.push_back(v);
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (ready_q[p] >= v)
                break;
            ready_q[i] = ready_q[p];
            i = p;
        end
        ready_q[i] = v;
    endfunction

    function logic [31:0] ready_pop();
        logic [31:0] top;
        logic [31:0] last;
        int i;
        int c;
        int n;
        top = ready_q[0];
        last = ready_q.pop_back();
        n = ready_q.size();
        i = 0;
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && ready_q[c + 1] > ready_q[c])
                c++;
            if (ready_q[c] <= last)
                break;
            ready_q[i] = ready_q[c];
            i = c;
        end
        if (n > 0)
            ready_q[i] = last;
        return top;
    endfunction

    function bit pend_first(logic [47:0] a, logic [47:0] b);
        if (a[47:32] != b[47:32])
            return a[47:32] < b[47:32];
        return a[31:0] > b[31:0];
    endfunction

    function void pend_push(logic [47:0] v);
        int i;
        int p;
        i = pend_q.size();
        pend_q.push_back(v);
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!pend_first(v, pend_q[p]))
                break;
            pend_q[i] = pend_q[p];
            i = p;
        end
        pend_q[i] = v;
    endfunction

    function void pend_pop();
        logic [47:0] last;
        int i;
        int c;
        int n;
        last = pend_q.pop_back();
        n = pend_q.size();
        i = 0;
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && pend_first(pend_q[c + 1], pend_q[c]))
                c++;
            if (!pend_first(pend_q[c], last))
                break;
            pend_q[i] = pend_q[c];
            i = c;
        end
        if (n > 0)
            pend_q[i] = last;
    endfunction

    function void note_item(logic kind, logic [15:0] rel, logic [31:0] prio);
        sched_result_t r;
        logic [31:0] w;
        r = '0;
        if (kind == 1'b0)
        begin
            r.status = rtps_pkg::ST_INSERT_OK;
            if (rel <= cur_time)
            begin
                if (ready_q.size() >= CAP)
                    r.status = rtps_pkg::ST_DROPPED;
                else
                    ready_push(prio);
            end
            else
            begin
                if (pend_q.size() >= CAP)
                    r.status = rtps_pkg::ST_DROPPED;
                else
                    pend_push({rel, prio});
            end
        end
        else
        begin
            while (pend_q.size() > 0 && ready_q.size() < CAP
                   && pend_q[0][47:32] <= cur_time)
            begin
                w = pend_q[0][31:0];
                pend_pop();
                ready_push(w);
            end
            r.stime = cur_time;
            if (ready_q.size() == 0)
                r.status = rtps_pkg::ST_EMPTY;
            else
            begin
                w = ready_pop();
                r.status = rtps_pkg::ST_SERVED;
                r.prio = w;
                r.watched = (w == watch_prio);
            end
            cur_time = cur_time + 16'd1;
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
        sched_result_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected transfer, actual %h", $time, got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        if (got.prio !== e.prio)
            $display("%0t: served_priority expected %h actual %h", $time, e.prio, got.prio);
        if (got.stime !== e.stime)
            $display("%0t: served_time expected %0d actual %0d", $time, e.stime, got.stime);
        if (got.watched !== e.watched)
            $display("%0t: is_watched expected %0d actual %0d", $time, e.watched,
                     got.watched);
        if (got !== e)
            errors++;
    endfunction
endclass

module release_time_priority_scheduler_top_test
    import rtps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] release_time;
    logic [31:0] priority_req;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] served_priority;
    logic [15:0] served_time;
    logic        is_watched;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    sched_scoreboard sb;
    bit stall_enable;
    bit hold_off;
    int idle_cycles;

    release_time_priority_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .release_time(release_time), .priority_req(priority_req),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .served_priority(served_priority),
        .served_time(served_time), .is_watched(is_watched),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic send_item(logic k, logic [15:0] rel, logic [31:0] prio, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        release_time <= rel;
        priority_req <= prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(k, rel, prio);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_TIME)
            sb.set_start(data[15:0]);
        else
            sb.set_watch(data);
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_rel(logic [15:0] now);
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return now - 16'($urandom_range(0, 20));
            default: return now + 16'($urandom_range(0, 30));
        endcase
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n || !stall_enable)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (out_stall)
            out_stall <= ($urandom_range(0, 2) != 0);
        else
            out_stall <= ($urandom_range(0, 5) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, served_priority, served_time, is_watched});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] wp;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        release_time = '0;
        priority_req = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_START_TIME;
        cfg_data = '0;
        stall_enable = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset time, extremes, empty tick, due and pending entries
        send_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_item(1'b0, 16'd0, 32'hFFFF_FFFF, 0);
        send_item(1'b0, 16'd2011, 32'd0, 0);
        send_item(1'b0, 16'd2012, 32'h5555_5555, 0);
        send_item(1'b0, 16'd2012, 32'hAAAA_AAAA, 0);
        send_item(1'b0, 16'hFFFF, 32'd7, 0);
        send_item(1'b0, 16'd2011, 32'd0, 0);
        repeat (6) send_item(1'b1, 16'd0, 32'd0, 0);
        drain();

        write_reg(CFG_WATCHED, 32'hAAAA_AAAA);
        write_reg(CFG_START_TIME, 32'h0000_FFFE);
        send_item(1'b0, 16'hFFFF, 32'hAAAA_AAAA, 0);
        send_item(1'b0, 16'd0, 32'd3, 0);
        send_item(1'b0, 16'd1, 32'd9, 0);
        repeat (4) send_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 0);
        drain();

        stall_enable = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_reg(CFG_START_TIME, 32'd0);
                1: write_reg(CFG_START_TIME, 32'd65535);
                2: write_reg(CFG_START_TIME, $urandom());
                default: write_reg(CFG_START_TIME, 32'd2011);
            endcase
            wp = (phase == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 40);
            write_reg(CFG_WATCHED, wp);
            if (phase == 1)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int n = 0; n < 480; n++)
            begin
                if (phase == 2 && n == 240)
                    drain();
                if ($urandom_range(0, 4) < 2)
                    send_item(1'b1, 16'($urandom()), $urandom(), phase < 3);
                else if ($urandom_range(0, 3) == 0)
                    send_item(1'b0, rand_rel(sb.cur_time), $urandom(), phase < 3);
                else
                    send_item(1'b0, rand_rel(sb.cur_time),
                              (n % 5 == 0) ? wp : $urandom_range(0, 40), phase < 3);
            end
            if (phase == 2)
                stall_enable = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
